// ===== rtl/core/assert_macros.svh =====
// assertion helper macros shared by the rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/pph_pkg.sv =====
// types, constants and helpers for the parallel printer port handshake
// no dependencies
package pph_pkg;

   localparam int unsigned CNT_W  = 16;
   localparam int unsigned DATA_W = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // reset values of the timing registers
   localparam logic [CNT_W-1:0] ACK_DELAY_RST     = 16'd10;
   localparam logic [CNT_W-1:0] BUSY_RELEASE_RST  = 16'd7;
   localparam logic [CNT_W-1:0] ACK_WIDTH_RST     = 16'd5;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_WRITE_BYTE = 3'd1,
      OP_SET_BIT    = 3'd2,
      OP_STROBE     = 3'd3,
      OP_ONLINE     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE         = 2'd0,
      PH_WAIT_ACK     = 2'd1,
      PH_WAIT_RELEASE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CSR_ACK_DELAY    = 2'd0,
      CSR_BUSY_RELEASE = 2'd1,
      CSR_ACK_WIDTH    = 2'd2
   } csr_index_type;

   // one accepted input item held in the input register
   typedef struct packed {
      logic [2:0]        op;
      logic [DATA_W-1:0] data_byte;
      logic [2:0]        bit_index;
      logic              line_level;
   } req_item_type;

   // saturating tick counter increment
   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      bump = (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
   endfunction

endpackage

// ===== rtl/core/parallel_printer_port_handshake.sv =====
// printer side of a parallel port handshake, top level
// depends on pph_pkg and assert_macros.svh
`include "assert_macros.svh"

// Printer-side model of a parallel port handshake. Each transfer on req_ is one
// operation: a timer tick, a byte write, a single data bit write, a new strobe
// level or a new online level. Each produces exactly one transfer on rsp_ that
// reports every line after the operation, plus the printed byte when the
// acknowledge pulse started on that tick. Throughput is one operation per clock
// while rsp_ready stays high: the input register feeds the line state logic,
// which loads the result register. The csr_ timing registers count ticks
// (0 acts like 1) and are to be written only while no operation is in flight.
module parallel_printer_port_handshake (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [2:0]  req_bit_index,
   input  logic        req_line_level,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_read,
   output logic        rsp_ack_level,
   output logic        rsp_busy_level,
   output logic        rsp_not_busy_level,
   output logic        rsp_paper_empty_level,
   output logic        rsp_fault_level,
   output logic        rsp_printed_valid,
   output logic [7:0]  rsp_printed_byte,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [pph_pkg::CNT_W-1:0] ack_delay_ff, busy_release_ff, ack_width_ff;

   // line state
   logic [pph_pkg::DATA_W-1:0] data_latch_ff, data_latch_in;
   logic strobe_prev_ff, strobe_prev_in;
   logic busy_flag_ff, busy_flag_in;
   logic ack_flag_ff, ack_flag_in;
   logic paper_empty_ff, paper_empty_in;
   logic fault_ff, fault_in;
   pph_pkg::phase_type phase_ff, phase_in;
   logic [pph_pkg::CNT_W-1:0] phase_count_ff, phase_count_in;
   logic ack_pending_ff, ack_pending_in;
   logic [pph_pkg::CNT_W-1:0] ack_count_ff, ack_count_in;

   // input register
   logic                  item_valid_ff;
   pph_pkg::req_item_type item_ff;

   // print event of the current item
   logic                       print_now;
   logic [pph_pkg::DATA_W-1:0] print_byte;
   logic [pph_pkg::CNT_W-1:0]  phase_bump, ack_bump;

   logic advance;

   // pipeline flow control
   assign advance   = item_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_delay_ff    <= pph_pkg::ACK_DELAY_RST;
         busy_release_ff <= pph_pkg::BUSY_RELEASE_RST;
         ack_width_ff    <= pph_pkg::ACK_WIDTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pph_pkg::CSR_ACK_DELAY:    ack_delay_ff    <= csr_wdata;
            pph_pkg::CSR_BUSY_RELEASE: busy_release_ff <= csr_wdata;
            pph_pkg::CSR_ACK_WIDTH:    ack_width_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.op         <= req_op;
         item_ff.data_byte  <= req_data_byte;
         item_ff.bit_index  <= req_bit_index;
         item_ff.line_level <= req_line_level;
      end
   end

   assign phase_bump = pph_pkg::bump(phase_count_ff);
   assign ack_bump   = pph_pkg::bump(ack_count_ff);

   // line state update for the held item
   always_comb begin
      data_latch_in  = data_latch_ff;
      strobe_prev_in = strobe_prev_ff;
      busy_flag_in   = busy_flag_ff;
      ack_flag_in    = ack_flag_ff;
      paper_empty_in = paper_empty_ff;
      fault_in       = fault_ff;
      phase_in       = phase_ff;
      phase_count_in = phase_count_ff;
      ack_pending_in = ack_pending_ff;
      ack_count_in   = ack_count_ff;
      print_now      = 1'b0;
      print_byte     = '0;
      unique case (pph_pkg::op_type'(item_ff.op))
         pph_pkg::OP_TICK: begin
            // ack return timer goes first
            if (ack_pending_ff) begin
               if (ack_bump >= ack_width_ff) begin
                  ack_flag_in    = 1'b1;
                  ack_pending_in = 1'b0;
                  ack_count_in   = '0;
               end else begin
                  ack_count_in = ack_bump;
               end
            end
            unique case (phase_ff)
               pph_pkg::PH_WAIT_ACK: begin
                  if (phase_bump >= ack_delay_ff) begin
                     ack_flag_in    = 1'b0;
                     print_now      = 1'b1;
                     print_byte     = data_latch_ff;
                     phase_in       = pph_pkg::PH_WAIT_RELEASE;
                     phase_count_in = '0;
                  end else begin
                     phase_count_in = phase_bump;
                  end
               end
               pph_pkg::PH_WAIT_RELEASE: begin
                  if (phase_bump >= busy_release_ff) begin
                     busy_flag_in   = 1'b0;
                     phase_in       = pph_pkg::PH_IDLE;
                     phase_count_in = '0;
                     ack_pending_in = 1'b1;
                     ack_count_in   = '0;
                  end else begin
                     phase_count_in = phase_bump;
                  end
               end
               default: begin
                  phase_in       = pph_pkg::PH_IDLE;
                  phase_count_in = '0;
               end
            endcase
         end
         pph_pkg::OP_WRITE_BYTE: begin
            data_latch_in = item_ff.data_byte;
         end
         pph_pkg::OP_SET_BIT: begin
            data_latch_in[item_ff.bit_index] = item_ff.line_level;
         end
         pph_pkg::OP_STROBE: begin
            // falling strobe while not busy starts a print cycle
            if (strobe_prev_ff && !item_ff.line_level && !busy_flag_ff) begin
               busy_flag_in   = 1'b1;
               phase_in       = pph_pkg::PH_WAIT_ACK;
               phase_count_in = '0;
            end
            strobe_prev_in = item_ff.line_level;
         end
         pph_pkg::OP_ONLINE: begin
            paper_empty_in = item_ff.line_level;
            fault_in       = item_ff.line_level;
            busy_flag_in   = !item_ff.line_level;
         end
         default: ;
      endcase
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         data_latch_ff  <= '0;
         strobe_prev_ff <= 1'b1;
         busy_flag_ff   <= 1'b1;
         ack_flag_ff    <= 1'b1;
         paper_empty_ff <= 1'b0;
         fault_ff       <= 1'b0;
         phase_ff       <= pph_pkg::PH_IDLE;
         phase_count_ff <= '0;
         ack_pending_ff <= 1'b0;
         ack_count_ff   <= '0;
      end else if (advance) begin
         data_latch_ff  <= data_latch_in;
         strobe_prev_ff <= strobe_prev_in;
         busy_flag_ff   <= busy_flag_in;
         ack_flag_ff    <= ack_flag_in;
         paper_empty_ff <= paper_empty_in;
         fault_ff       <= fault_in;
         phase_ff       <= phase_in;
         phase_count_ff <= phase_count_in;
         ack_pending_ff <= ack_pending_in;
         ack_count_ff   <= ack_count_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (advance) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_read         <= data_latch_in;
         rsp_ack_level         <= ack_flag_in;
         rsp_busy_level        <= busy_flag_in;
         rsp_not_busy_level    <= !busy_flag_in;
         rsp_paper_empty_level <= paper_empty_in;
         rsp_fault_level       <= fault_in;
         rsp_printed_valid     <= print_now;
         rsp_printed_byte      <= print_byte;
      end
   end

   // checks
   `ASSERT_NEXT(a_print_drops_ack, clock, reset, advance && print_now, !ack_flag_ff && phase_ff == pph_pkg::PH_WAIT_RELEASE)
   `ASSERT_IMPLIES(a_idle_count_clear, clock, reset, phase_ff == pph_pkg::PH_IDLE, phase_count_ff == '0)
   `ASSERT_IMPLIES(a_ack_count_clear, clock, reset, !ack_pending_ff, ack_count_ff == '0)
   `ASSERT_IMPLIES(a_no_print_zero_byte, clock, reset, rsp_valid && !rsp_printed_valid, rsp_printed_byte == '0)

endmodule
